// ===== rtl/core/cifc_pkg.sv =====
// Package for the cell index / fraction codec: register map, reset values,
// pipeline stage types and the restoring divide step.
// No dependencies.
package cifc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IDX_BITS  = 16;
   localparam int DEF_MAX_CELLS = 256;

   localparam int CSR_AW = 3;
   localparam logic REG_DIAMETER   = 1'b0;
   localparam logic REG_CELL_COUNT = 1'b1;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [30:0] DIAMETER_RESET   = 31'd8192;
   localparam logic [8:0]  CELL_COUNT_RESET = 9'd16;

   // quotient bits of (n << 16) / r: 16 index bits and 16 fraction bits
   localparam int DIV_BITS   = IDX_BITS + FRAC_BITS;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic        neg;
      logic [30:0] mag;
      logic [29:0] r;
      logic [15:0] cntm1;
      logic [15:0] kidx;
      logic [15:0] frac;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic        neg;
      logic [30:0] mag;
      logic [29:0] r;
      logic [15:0] cntm1;
      logic [45:0] m1;
      logic [45:0] m2;
   } s2_type;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic        neg;
      logic        zero;
      logic        clamp;
      logic [15:0] cntm1;
      logic [29:0] r;
      logic [29:0] rem;
      logic [15:0] low;
      logic [31:0] q;
      logic [31:0] dres;
   } div_type;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   function automatic div_type div_step(input div_type d);
      logic [30:0] t;
      div_type     o;
      begin
         o = d;
         t = {d.rem, d.low[15]};
         o.low = {d.low[14:0], 1'b0};
         if (t >= {1'b0, d.r}) begin
            o.rem = 30'(t - {1'b0, d.r});
            o.q   = {d.q[30:0], 1'b1};
         end else begin
            o.rem = t[29:0];
            o.q   = {d.q[30:0], 1'b0};
         end
         return o;
      end
   endfunction

endpackage

// ===== rtl/core/cell_index_fraction_codec.sv =====
// Cell index / fraction codec top level: CSR block and the full datapath pipeline.
// Depends on cifc_pkg.
//
// One item enters per clock while req_ready is high and one result leaves per clock
// when the output side takes it. The accepting edge loads the first of twenty
// registers, which are three stages for magnitude, the two 16x30 products and the
// range clamp, sixteen stages of a pipelined restoring divider retiring two
// quotient bits each, and the output register. Decode items ride the same stages
// so order is kept. A stall at the output holds every stage; req_ready is low only
// while a result waits unclaimed.
// Registers: diameter at byte 0, cell_count at byte 4.
module cell_index_fraction_codec #(
   parameter int MAX_CELLS = cifc_pkg::DEF_MAX_CELLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [31:0]            req_value_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_value_out,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cifc_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import cifc_pkg::*;

   localparam logic [16:0] MAX_C = 17'(MAX_CELLS);

   logic [30:0] diameter_ff;
   logic [8:0]  cell_count_ff;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   div_type div_ff [0:DIV_STAGES];
   div_type div0_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        adv;

   // ---------------- configuration ----------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff   <= DIAMETER_RESET;
         cell_count_ff <= CELL_COUNT_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_DIAMETER:   diameter_ff   <= pwdata[30:0];
            REG_CELL_COUNT: cell_count_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DIAMETER:   prdata = {1'b0, diameter_ff};
         REG_CELL_COUNT: prdata = {23'b0, cell_count_ff};
         default:        prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: magnitude, cell size, count ----------------
   always_comb begin
      logic [16:0] cnt;
      logic [31:0] v;
      logic [30:0] mag;
      logic [15:0] didx;
      v   = req_value_in;
      cnt = {8'b0, cell_count_ff};
      if (cnt > MAX_C) cnt = MAX_C;
      if (cnt == 17'd0) cnt = 17'd1;
      if (!v[31])                 mag = v[30:0];
      else if (v == 32'h8000_0000) mag = 31'h7FFF_FFFF;
      else                         mag = 31'(32'd0 - v);
      didx = {1'b0, mag[30:16]};
      if ({1'b0, didx} >= cnt) didx = '0;
      s1_in.valid = req_valid;
      s1_in.op    = req_op;
      s1_in.neg   = v[31];
      s1_in.mag   = mag;
      s1_in.r     = diameter_ff[30:1];
      s1_in.cntm1 = 16'(cnt - 17'd1);
      s1_in.kidx  = (req_op == OP_DECODE) ? didx : 16'(cnt - 17'd1);
      s1_in.frac  = mag[15:0];
   end

   // ---------------- stage 2: products ----------------
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.op    = s1_ff.op;
      s2_in.neg   = s1_ff.neg;
      s2_in.mag   = s1_ff.mag;
      s2_in.r     = s1_ff.r;
      s2_in.cntm1 = s1_ff.cntm1;
      s2_in.m1    = {30'b0, s1_ff.kidx} * {16'b0, s1_ff.r};
      s2_in.m2    = {30'b0, s1_ff.frac} * {16'b0, s1_ff.r};
   end

   // ---------------- stage 3: clamp and divider setup, decode sum ----------------
   always_comb begin
      logic [46:0] lim;
      logic [30:0] num;
      lim = {1'b0, s2_ff.m1} + {17'b0, s2_ff.r};
      div0_in.valid = s2_ff.valid;
      div0_in.op    = s2_ff.op;
      div0_in.neg   = s2_ff.neg;
      div0_in.zero  = (s2_ff.r == 30'd0);
      div0_in.clamp = ({16'b0, s2_ff.mag} >= lim);
      div0_in.cntm1 = s2_ff.cntm1;
      div0_in.r     = s2_ff.r;
      // past the last cell the remainder saturates at r-1
      num = div0_in.clamp ? {1'b0, 30'(s2_ff.r - 30'd1)} : s2_ff.mag;
      div0_in.rem   = {15'b0, num[30:16]};
      div0_in.low   = num[15:0];
      div0_in.q     = '0;
      div0_in.dres  = s2_ff.m1[31:0] + {2'b0, s2_ff.m2[45:16]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid     <= 1'b0;
         s2_ff.valid     <= 1'b0;
         div_ff[0].valid <= 1'b0;
      end else if (adv) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         div_ff[0] <= div0_in;
      end
   end

   // ---------------- divider stages ----------------
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      div_type st_in;
      always_comb begin
         st_in = div_ff[g];
         for (int k = 0; k < DIV_STEPS; k++) begin
            st_in = div_step(st_in);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g+1].valid <= 1'b0;
         end else if (adv) begin
            div_ff[g+1] <= st_in;
         end
      end
   end

   // ---------------- output ----------------
   always_comb begin
      div_type     d;
      logic [15:0] idx;
      logic [15:0] frac;
      logic [31:0] w;
      d = div_ff[DIV_STAGES];
      if (d.zero) begin
         idx  = d.cntm1;
         frac = '0;
      end else begin
         idx  = d.clamp ? d.cntm1 : d.q[31:16];
         frac = d.q[15:0];
      end
      w = (d.op == OP_DECODE) ? d.dres : {idx, frac};
      rsp_value_in = d.neg ? 32'd0 - w : w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_ff[DIV_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule
